// File: design/cie_pkg.sv
// Package for the CBOR item head encoder: request/response payload types,
// operation codes, CBOR constants and the head-building function.
// No dependencies.
package cie_pkg;

  // Operation codes of an input request
  typedef enum logic [3:0] {
    OP_NULL    = 4'd0,
    OP_BOOL    = 4'd1,
    OP_UINT    = 4'd2,
    OP_SINT    = 4'd3,
    OP_DOUBLE  = 4'd4,
    OP_TEXT    = 4'd5,
    OP_BYTES   = 4'd6,
    OP_LIST    = 4'd7,
    OP_MAP     = 4'd8,
    OP_LINK    = 4'd9,
    OP_PAYLOAD = 4'd10
  } op_e;

  // CBOR major types
  localparam logic [2:0] MajUint  = 3'd0;
  localparam logic [2:0] MajNint  = 3'd1;
  localparam logic [2:0] MajBytes = 3'd2;
  localparam logic [2:0] MajText  = 3'd3;
  localparam logic [2:0] MajArray = 3'd4;
  localparam logic [2:0] MajMap   = 3'd5;

  // Fixed encoded bytes
  localparam logic [7:0] ByteFalse  = 8'hF4;
  localparam logic [7:0] ByteTrue   = 8'hF5;
  localparam logic [7:0] ByteNull   = 8'hF6;
  localparam logic [7:0] ByteDouble = 8'hFB;
  localparam logic [7:0] ByteTag1   = 8'hD8;  // major 6, one-byte argument
  localparam logic [7:0] ByteTagCid = 8'd42;

  localparam logic [63:0] QuietNan = 64'h7FF8_0000_0000_0000;

  localparam int unsigned MaxBytes = 12;
  localparam int unsigned HeadMax  = 9;

  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] value_bits;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       links_seen;
    logic       not_dag_flag;
  } out_rsp_t;

  // One CBOR head, first byte at index 0, unused bytes zero
  typedef struct packed {
    logic [HeadMax-1:0][7:0] bytes;
    logic [3:0]              len;
  } head_t;

  // Encoded item, first byte at index 0, plus flag updates
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
    logic                     set_link;
    logic                     set_notdag;
  } enc_t;

  // Shortest-form head for a major type and argument
  function automatic head_t cbor_head(logic [2:0] major, logic [63:0] arg);
    head_t h;
    h = '0;
    if (arg < 64'd24) begin
      h.bytes[0] = {major, arg[4:0]};
      h.len      = 4'd1;
    end else if (arg < 64'h100) begin
      h.bytes[0] = {major, 5'd24};
      h.bytes[1] = arg[7:0];
      h.len      = 4'd2;
    end else if (arg < 64'h1_0000) begin
      h.bytes[0] = {major, 5'd25};
      h.bytes[1] = arg[15:8];
      h.bytes[2] = arg[7:0];
      h.len      = 4'd3;
    end else if (arg < 64'h1_0000_0000) begin
      h.bytes[0] = {major, 5'd26};
      for (int k = 0; k < 4; k++) begin
        h.bytes[1+k] = arg[8*(3-k) +: 8];
      end
      h.len      = 4'd5;
    end else begin
      h.bytes[0] = {major, 5'd27};
      for (int k = 0; k < 8; k++) begin
        h.bytes[1+k] = arg[8*(7-k) +: 8];
      end
      h.len      = 4'd9;
    end
    return h;
  endfunction

endpackage

// File: design/cie_encode.sv
// Combinational encoder: turns one registered request into its CBOR bytes,
// byte count and sticky flag updates. Depends on cie_pkg.
module cie_encode (
  input  cie_pkg::in_req_t req_i,
  output cie_pkg::enc_t    enc_o
);
  import cie_pkg::*;

  op_e         op;
  logic [63:0] v;
  logic        exp_ones;
  head_t       h_main;
  head_t       h_link;
  logic [2:0]  major;
  logic [63:0] arg;
  logic [63:0] dbl;

  assign op       = op_e'(req_i.operation);
  assign v        = req_i.value_bits;
  assign exp_ones = (v[62:52] == 11'h7FF);
  assign dbl      = (exp_ones && (v[51:0] != '0)) ? QuietNan : v;

  // Major type and argument for the single-head items
  always_comb begin
    major = MajUint;
    arg   = v;
    unique case (op)
      OP_SINT:  begin
        major = v[63] ? MajNint : MajUint;
        arg   = v[63] ? ~v : v;
      end
      OP_TEXT:  major = MajText;
      OP_BYTES: major = MajBytes;
      OP_LIST:  major = MajArray;
      OP_MAP:   major = MajMap;
      default:  major = MajUint;
    endcase
  end

  assign h_main = cbor_head(major, arg);
  assign h_link = cbor_head(MajBytes, v + 64'd1);

  // Assemble the byte sequence
  always_comb begin
    enc_o = '0;
    unique case (op)
      OP_NULL: begin
        enc_o.bytes[0] = ByteNull;
        enc_o.len      = 4'd1;
      end
      OP_BOOL: begin
        enc_o.bytes[0] = (v != '0) ? ByteTrue : ByteFalse;
        enc_o.len      = 4'd1;
      end
      OP_UINT, OP_SINT, OP_TEXT, OP_BYTES, OP_LIST, OP_MAP: begin
        for (int k = 0; k < HeadMax; k++) begin
          enc_o.bytes[k] = h_main.bytes[k];
        end
        enc_o.len        = h_main.len;
        enc_o.set_notdag = (op == OP_UINT) && v[63];
      end
      OP_DOUBLE: begin
        enc_o.bytes[0] = ByteDouble;
        for (int k = 0; k < 8; k++) begin
          enc_o.bytes[1+k] = dbl[8*(7-k) +: 8];
        end
        enc_o.len        = 4'd9;
        enc_o.set_notdag = exp_ones;
      end
      OP_LINK: begin
        // tag 42, byte-string head, then the zero multibase byte (already zero)
        enc_o.bytes[0] = ByteTag1;
        enc_o.bytes[1] = ByteTagCid;
        for (int k = 0; k < HeadMax; k++) begin
          enc_o.bytes[2+k] = h_link.bytes[k];
        end
        enc_o.len      = h_link.len + 4'd3;
        enc_o.set_link = 1'b1;
      end
      OP_PAYLOAD: begin
        enc_o.bytes[0] = v[7:0];
        enc_o.len      = 4'd1;
      end
      default: enc_o = '0;  // unknown operation: no bytes
    endcase
  end

endmodule

// File: design/cie_serializer.sv
// Byte serializer: holds one encoded item in a shift buffer and feeds it
// byte by byte into the output register. Depends on cie_pkg.
module cie_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cie_pkg::enc_t     enc_i,
  input  logic              links_i,
  input  logic              notdag_i,
  output logic              can_load_o,
  output logic [3:0]        cnt_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cie_pkg::out_rsp_t out_rsp_o
);
  import cie_pkg::*;

  logic [MaxBytes-1:0][7:0] bytes_q;
  logic [3:0]               cnt_q;
  logic                     links_q;
  logic                     notdag_q;
  logic                     out_valid_q;
  out_rsp_t                 out_q;
  logic                     move;

  // Next byte moves when the output register is free or being drained
  assign move       = (cnt_q != 4'd0) && (!out_valid_q || out_ready_i);
  assign can_load_o = (cnt_q == 4'd0) || ((cnt_q == 4'd1) && move);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_i) begin
        cnt_q <= enc_i.len;
      end else if (move) begin
        cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  // Byte buffer and output payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q.out_byte     <= bytes_q[0];
      out_q.last_byte    <= (cnt_q == 4'd1);
      out_q.links_seen   <= links_q;
      out_q.not_dag_flag <= notdag_q;
    end
    if (load_i) begin
      bytes_q  <= enc_i.bytes;
      links_q  <= links_i;
      notdag_q <= notdag_i;
    end else if (move) begin
      bytes_q <= bytes_q >> 8;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cnt_o       = cnt_q;

endmodule

// File: design/cbor_item_head_encoder.sv
// Top level of the CBOR item head encoder: input register, sticky flags,
// encoder and byte serializer. Depends on cie_pkg, cie_encode, cie_serializer.
//
//   channel | signals                            | moves
//   --------+------------------------------------+----------------------------
//   in      | in_valid_i, in_ready_o, in_req_i   | one data-model request
//   out     | out_valid_o, out_ready_i, out_rsp_o| one encoded byte + flags
//
// Each known request yields 1 to 12 bytes, one per cycle unless the output
// stalls; an unknown operation yields none. The next request is encoded and
// loaded while the last byte of the current one moves out, so one-byte
// requests flow at one per cycle without output stalls. A request passes the
// input register, byte buffer and output register. Reset clears the flags
// and all valid state; an output stall holds a non-empty byte buffer.
module cbor_item_head_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cie_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cie_pkg::out_rsp_t out_rsp_o
);
  import cie_pkg::*;

  logic       in_valid_q;
  in_req_t    in_req_q;
  enc_t       enc;
  logic       can_load;
  logic       load;
  logic       links_q;
  logic       links_d;
  logic       notdag_q;
  logic       notdag_d;
  logic [3:0] cnt;

  assign load       = in_valid_q && can_load;
  assign in_ready_o = !in_valid_q || load;

  // Sticky flags after this request's update
  assign links_d  = links_q  | (load & enc.set_link);
  assign notdag_d = notdag_q | (load & enc.set_notdag);

  // Input register and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      links_q    <= 1'b0;
      notdag_q   <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      links_q  <= links_d;
      notdag_q <= notdag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
  end

  cie_encode u_encode (
    .req_i (in_req_q),
    .enc_o (enc)
  );

  cie_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .enc_i       (enc),
    .links_i     (links_d),
    .notdag_i    (notdag_d),
    .can_load_o  (can_load),
    .cnt_o       (cnt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef SYNTHESIS
  // Flags never clear once set
  a_links_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    links_q |=> links_q) else $error("links flag dropped");

  a_notdag_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    notdag_q |=> notdag_q) else $error("not-DAG flag dropped");

  // Byte buffer never holds more than one item's worth
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= 4'd12) else $error("byte count out of range");

  // Empty input register always takes a request
  a_in_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o) else $error("input stalled while empty");

  // A reported link implies the internal flag is set
  a_link_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.links_seen) |-> links_q)
    else $error("link flag ahead of state");
`endif

endmodule
